>>> rtl/core/tcs_pkg.sv
// Shared types and constants for the telnet command stripper.
// Holds telnet command codes, parser phase codes and the parser result record.
// No dependencies.
`default_nettype none

package tcs_pkg;

  // Telnet command codes
  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] OPT_ECHO = 8'd1;

  // Negotiation verb, stored as command code minus WILL
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;

  // Parser phase codes, one parser per direction
  localparam logic [2:0] PH_DATA    = 3'd0;
  localparam logic [2:0] PH_IAC     = 3'd1;
  localparam logic [2:0] PH_OPTION  = 3'd2;
  localparam logic [2:0] PH_SB_OPT  = 3'd3;
  localparam logic [2:0] PH_SB      = 3'd4;
  localparam logic [2:0] PH_SB_IAC  = 3'd5;
  localparam logic [2:0] PH_UNUSED6 = 3'd6;
  localparam logic [2:0] PH_UNUSED7 = 3'd7;

  // Result of parsing one byte
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       rec;
  } tcs_res_t;

endpackage

`default_nettype wire

>>> rtl/core/telnet_command_stripper.sv
// Telnet command stripper, top level.
// Input beat register, tcs_parser decode, result register; uses tcs_pkg.
//
// Usage:
//   in_*  channel: one raw telnet byte per beat in in_tdata, the sending
//         direction in in_tuser. Accepted when in_tvalid and in_tready are high.
//   out_* channel: one payload byte per beat in out_tdata, with the sending
//         direction and the record-enable bit in out_tuser.
//   Command sequences (IAC commands, option negotiation, SB ... IAC SE) are
//   removed; IAC IAC yields one 255 byte. A byte that is part of a command
//   produces no output beat.
// Path: input register, then parser decode into the result register.
// Throughput: one byte per cycle while out_tready is high; the parser state
//   update is the only loop.
// Reset: both parsers return to the data phase, both echo flags clear,
//   both registers empty.
// Stall: while out_tready is low one result is held and one more input beat
//   is taken into the input register; then in_tready drops.
`default_nettype none

module telnet_command_stripper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] direction
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] out_byte
  output      logic [1:0] out_tuser   // [0] from_direction, [1] record_ok
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_dir_r;
  logic              advance;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [1:0]        out_user_r;
  tcs_pkg::tcs_res_t res;

  // Move the held byte through the parser when the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_dir_r  <= in_tuser;
    end
  end

  tcs_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .byte_i (in_byte_r),
    .dir_i  (in_dir_r),
    .res    (res)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_byte_r <= res.data;
      out_user_r <= {res.rec, in_dir_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;

  // Hold the input beat while the parser cannot take it
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(in_dir_r))
    else $error("input register lost a stalled byte");

  // A new result appears only from a parser step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without a parser step");

  // A dropped command byte leaves the result slot empty
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !res.emit |=> !out_valid_r)
    else $error("command byte produced a result");

endmodule

`default_nettype wire

>>> rtl/core/tcs_parser.sv
// Per-direction telnet command parser with echo tracking.
// Holds phase, verb and echo state for both directions; uses tcs_pkg.
// Produces the payload result for the byte presented on a step.
`default_nettype none

module tcs_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      byte_i,
  input  wire logic            dir_i,
  output tcs_pkg::tcs_res_t    res
);

  logic [2:0] phase_r [2];
  logic [2:0] phase_nxt [2];
  logic [1:0] verb_r [2];
  logic [1:0] verb_nxt [2];
  logic [1:0] echo_r;
  logic [1:0] echo_nxt;
  logic [2:0] cur_phase;
  logic       other;

  assign cur_phase = phase_r[dir_i];
  assign other     = ~dir_i;

  // Decode one byte against the sending side's parser
  always_comb begin
    phase_nxt = phase_r;
    verb_nxt  = verb_r;
    echo_nxt  = echo_r;
    res.emit  = 1'b0;
    res.data  = byte_i;
    res.rec   = ~echo_r[dir_i];
    case (cur_phase)
      tcs_pkg::PH_IAC: begin
        if (byte_i == tcs_pkg::CMD_IAC) begin
          res.emit          = 1'b1;
          phase_nxt[dir_i]  = tcs_pkg::PH_DATA;
        end else if (byte_i inside {[tcs_pkg::CMD_WILL:tcs_pkg::CMD_DONT]}) begin
          verb_nxt[dir_i]   = 2'(byte_i - tcs_pkg::CMD_WILL);
          phase_nxt[dir_i]  = tcs_pkg::PH_OPTION;
        end else if (byte_i == tcs_pkg::CMD_SB) begin
          phase_nxt[dir_i]  = tcs_pkg::PH_SB_OPT;
        end else begin
          phase_nxt[dir_i]  = tcs_pkg::PH_DATA;
        end
      end
      tcs_pkg::PH_OPTION: begin
        // WILL ECHO sets, WONT ECHO clears the opposite side's flag
        if (byte_i == tcs_pkg::OPT_ECHO) begin
          if (verb_r[dir_i] == tcs_pkg::VERB_WILL) begin
            echo_nxt[other] = 1'b1;
          end else if (verb_r[dir_i] == tcs_pkg::VERB_WONT) begin
            echo_nxt[other] = 1'b0;
          end
        end
        phase_nxt[dir_i] = tcs_pkg::PH_DATA;
      end
      tcs_pkg::PH_SB_OPT: begin
        phase_nxt[dir_i] = tcs_pkg::PH_SB;
      end
      tcs_pkg::PH_SB: begin
        phase_nxt[dir_i] = (byte_i == tcs_pkg::CMD_IAC) ? tcs_pkg::PH_SB_IAC
                                                         : tcs_pkg::PH_SB;
      end
      tcs_pkg::PH_SB_IAC: begin
        phase_nxt[dir_i] = (byte_i == tcs_pkg::CMD_SE) ? tcs_pkg::PH_DATA
                                                        : tcs_pkg::PH_SB;
      end
      default: begin
        // Data phase; unused codes behave the same
        if (byte_i == tcs_pkg::CMD_IAC) begin
          phase_nxt[dir_i] = tcs_pkg::PH_IAC;
        end else begin
          res.emit         = 1'b1;
          phase_nxt[dir_i] = tcs_pkg::PH_DATA;
        end
      end
    endcase
  end

  // Commit parser state on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r[0] <= tcs_pkg::PH_DATA;
      phase_r[1] <= tcs_pkg::PH_DATA;
      verb_r[0]  <= tcs_pkg::VERB_WILL;
      verb_r[1]  <= tcs_pkg::VERB_WILL;
      echo_r     <= 2'b00;
    end else if (step) begin
      phase_r <= phase_nxt;
      verb_r  <= verb_nxt;
      echo_r  <= echo_nxt;
    end
  end

  // A byte never touches the echo flag of its own direction
  a_echo0_own: assert property (@(posedge clk) disable iff (!rst_n)
    step && !dir_i |=> $stable(echo_r[0]))
    else $error("direction 0 byte changed its own echo flag");

  a_echo1_own: assert property (@(posedge clk) disable iff (!rst_n)
    step && dir_i |=> $stable(echo_r[1]))
    else $error("direction 1 byte changed its own echo flag");

  a_phase_used: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[0] != tcs_pkg::PH_UNUSED6 && phase_r[0] != tcs_pkg::PH_UNUSED7 &&
    phase_r[1] != tcs_pkg::PH_UNUSED6 && phase_r[1] != tcs_pkg::PH_UNUSED7)
    else $error("parser entered an unused phase");

endmodule

`default_nettype wire
